### hdl/chunk_dirty_rect_tracker_defines.svh
// Assertion macros shared by the chunk dirty rectangle tracker RTL.
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef CHUNK_DIRTY_RECT_TRACKER_DEFINES_SVH
`define CHUNK_DIRTY_RECT_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cdrt_pkg.sv
// Shared types, constants and rectangle functions for the chunk tracker.
// No dependencies; imported by every other file but cdrt_ram and the header.
`timescale 1ns / 1ps
`default_nettype none

package cdrt_pkg;

    localparam int MAX_TILES  = 1024;
    localparam int TILE_AW    = $clog2(MAX_TILES);
    localparam int COORD_BITS = 16;
    localparam int WIDE_W     = 25;
    localparam int ACT_W      = 3;
    localparam int PT_W       = 14;
    localparam int IDX_W      = 12;
    localparam int GRID_W     = 7;
    localparam int SIZE_W     = 13;
    localparam int PROD_W     = 2 * GRID_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int OUT_W      = 16;

    typedef logic signed [WIDE_W-1:0]     wide_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam wide_t COORD_HI = wide_t'((2 ** (COORD_BITS - 1)) - 1);
    localparam wide_t COORD_LO = -COORD_HI - wide_t'(1);

    typedef enum logic [ACT_W-1:0] {
        ACT_MARK      = 3'd0,
        ACT_MARK_NB   = 3'd1,
        ACT_ADVANCE   = 3'd2,
        ACT_RESET_IDX = 3'd3,
        ACT_RESET_PT  = 3'd4,
        ACT_QUERY_IDX = 3'd5,
        ACT_QUERY_PT  = 3'd6,
        ACT_RESET_ALL = 3'd7
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLS     = 3'd0,
        REG_ROWS     = 3'd1,
        REG_TILE_W   = 3'd2,
        REG_TILE_H   = 3'd3,
        REG_ORIGIN_X = 3'd4,
        REG_ORIGIN_Y = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV_X,
        ST_DIV_Y,
        ST_LOCATE,
        ST_DIV_I,
        ST_BOUNDS,
        ST_NB_H,
        ST_NB_V,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_MARK,
        OP_ADVANCE,
        OP_RESET
    } op_t;

    typedef enum logic [1:0] {
        NB_NONE,
        NB_HORIZ,
        NB_VERT
    } nb_t;

    typedef struct packed {
        logic [GRID_W-1:0] cols;
        logic [GRID_W-1:0] rows;
        logic [SIZE_W-1:0] tile_w;
        logic [SIZE_W-1:0] tile_h;
        logic [PT_W-1:0]   origin_x;
        logic [PT_W-1:0]   origin_y;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        cols:     GRID_W'(8),
        rows:     GRID_W'(8),
        tile_w:   SIZE_W'(64),
        tile_h:   SIZE_W'(64),
        origin_x: PT_W'(0),
        origin_y: PT_W'(0)
    };

    typedef struct packed {
        coord_t x_min;
        coord_t y_min;
        coord_t x_max;
        coord_t y_max;
    } rect_t;

    typedef struct packed {
        logic  active;
        logic  next_active;
        rect_t cur;
        rect_t work;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             is_active;
        rect_t            rect;
        logic [IDX_W-1:0] idx;
        logic             fault;
    } result_t;

    localparam result_t FAULT_RESULT = '{
        is_active: 1'b0,
        rect:      '0,
        idx:       '0,
        fault:     1'b1
    };

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        return (s == '0) ? SIZE_W'(1) : s;
    endfunction

    function automatic coord_t sat_coord(input wide_t v);
        wide_t t;
        t = (v > COORD_HI) ? COORD_HI : ((v < COORD_LO) ? COORD_LO : v);
        return coord_t'(t);
    endfunction

    function automatic wide_t clamp_wide(input wide_t v, input wide_t lo, input wide_t hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Empty rectangle: min one past the far bound, max one before the near bound.
    function automatic rect_t empty_rect(input wide_t bx, input wide_t by,
                                         input wide_t w, input wide_t h);
        rect_t r;
        r.x_min = sat_coord(bx + w);
        r.x_max = sat_coord(bx - wide_t'(1));
        r.y_min = sat_coord(by + h);
        r.y_max = sat_coord(by - wide_t'(1));
        return r;
    endfunction

    // Widen by -2/+3 around the point and clamp to the chunk bounds.
    function automatic rect_t mark_rect(input rect_t r, input wide_t px, input wide_t py,
                                        input wide_t bx, input wide_t by,
                                        input wide_t w, input wide_t h);
        wide_t lo_x;
        wide_t hi_x;
        wide_t lo_y;
        wide_t hi_y;
        rect_t o;
        lo_x = px - wide_t'(2);
        hi_x = px + wide_t'(3);
        lo_y = py - wide_t'(2);
        hi_y = py + wide_t'(3);
        lo_x = (lo_x < wide_t'(r.x_min)) ? lo_x : wide_t'(r.x_min);
        hi_x = (hi_x > wide_t'(r.x_max)) ? hi_x : wide_t'(r.x_max);
        lo_y = (lo_y < wide_t'(r.y_min)) ? lo_y : wide_t'(r.y_min);
        hi_y = (hi_y > wide_t'(r.y_max)) ? hi_y : wide_t'(r.y_max);
        o.x_min = sat_coord(clamp_wide(lo_x, bx, bx + w));
        o.x_max = sat_coord(clamp_wide(hi_x, bx, bx + w));
        o.y_min = sat_coord(clamp_wide(lo_y, by, by + h));
        o.y_max = sat_coord(clamp_wide(hi_y, by, by + h));
        return o;
    endfunction

endpackage

`default_nettype wire

### hdl/cdrt_cmd_if.sv
// Command channel of the chunk tracker: valid/ready plus one action item.
// Depends on cdrt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdrt_cmd_if;
    import cdrt_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [PT_W-1:0]  point_x;
    logic [PT_W-1:0]  point_y;
    logic [IDX_W-1:0] chunk_index;

    modport source (output valid, output action, output point_x, output point_y,
                    output chunk_index, input ready);
    modport sink   (input valid, input action, input point_x, input point_y,
                    input chunk_index, output ready);
endinterface

`default_nettype wire

### hdl/cdrt_rsp_if.sv
// Response channel of the chunk tracker: valid/ready plus one result item.
// Depends on cdrt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdrt_rsp_if;
    import cdrt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    is_active;
    logic signed [OUT_W-1:0] rect_x_min;
    logic signed [OUT_W-1:0] rect_y_min;
    logic signed [OUT_W-1:0] rect_x_max;
    logic signed [OUT_W-1:0] rect_y_max;
    logic [IDX_W-1:0]        addressed_index;
    logic                    fault;

    modport source (output valid, output is_active, output rect_x_min, output rect_y_min,
                    output rect_x_max, output rect_y_max, output addressed_index,
                    output fault, input ready);
    modport sink   (input valid, input is_active, input rect_x_min, input rect_y_min,
                    input rect_x_max, input rect_y_max, input addressed_index,
                    input fault, output ready);
endinterface

`default_nettype wire

### hdl/cdrt_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cdrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

### hdl/cdrt_div.sv
// Restoring divider, one quotient bit per cycle, for chunk location.
// Depends on cdrt_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module cdrt_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cdrt_pkg::PT_W-1:0]   dividend,
    input  logic [cdrt_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output logic [cdrt_pkg::PT_W-1:0]   quotient,
    output logic [cdrt_pkg::SIZE_W-1:0] remainder
);
    import cdrt_pkg::*;

    localparam int CNT_W = $clog2(PT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PT_W-1:0]   quo_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] dvs_reg;
    logic [PT_W-1:0]   shifted;
    logic [PT_W-1:0]   diff;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[PT_W-1]};
    assign fits    = shifted >= PT_W'(dvs_reg);
    assign diff    = shifted - PT_W'(dvs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(PT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[PT_W-2:0], fits};
            rem_reg <= fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### hdl/cdrt_ctrl.sv
// Sequencer and datapath of the chunk tracker: locates chunks, runs the
// read-modify-write on the chunk memory and builds results. Uses cdrt_pkg,
// cdrt_cmd_if, cdrt_ram and cdrt_div.
`timescale 1ns / 1ps
`default_nettype none
`include "chunk_dirty_rect_tracker_defines.svh"

module cdrt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  cdrt_pkg::cfg_t    cfg,
    cdrt_cmd_if.sink          cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output cdrt_pkg::result_t res
);
    import cdrt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Item and location registers.
    action_t            act_reg;
    logic [PT_W-1:0]    px_reg;
    logic [PT_W-1:0]    py_reg;
    logic [IDX_W-1:0]   cidx_reg;
    logic [PT_W-1:0]    cx_reg;
    logic [PT_W-1:0]    cy_reg;
    logic [SIZE_W-1:0]  remx_reg;
    logic [SIZE_W-1:0]  remy_reg;
    logic [TILE_AW-1:0] idx_reg;
    logic [TILE_AW-1:0] tgt_reg;
    wide_t              bx_reg;
    wide_t              by_reg;
    wide_t              tbx_reg;
    wide_t              tby_reg;
    wide_t              mx_reg;
    wide_t              my_reg;
    op_t                op_reg;
    nb_t                nb_reg;
    result_t            res_reg;
    logic               sweep_cmd_reg;

    // Sweep registers hold a copy of the configuration taken at its start.
    logic [TILE_AW-1:0] sw_addr_reg;
    logic [GRID_W-1:0]  sw_col_reg;
    logic [GRID_W-1:0]  sw_cols_reg;
    logic [SIZE_W-1:0]  sw_tw_reg;
    logic [SIZE_W-1:0]  sw_th_reg;
    logic [PT_W-1:0]    sw_ox_reg;
    wide_t              sw_bx_reg;
    wide_t              sw_by_reg;

    logic [GRID_W-1:0]  cols_eff;
    logic [SIZE_W-1:0]  twe;
    logic [SIZE_W-1:0]  the;
    logic [PROD_W-1:0]  grid_prod;
    logic               accept;
    logic               idx_ok;
    logic               pt_below;
    logic               is_idx_act;
    logic               sw_last;
    logic [PROD_W-1:0]  idx_calc;
    logic               loc_ok;
    logic [GRID_W+SIZE_W-1:0]  prod_x;
    logic [TILE_AW+SIZE_W-1:0] prod_y;

    logic               nb_h_left;
    logic               nb_h_right;
    logic               nb_v_up;
    logic               nb_v_down;
    logic [PROD_W:0]    nb_h_idx;
    logic [PROD_W:0]    nb_v_idx;
    logic               nb_h_go;
    logic               nb_v_go;

    logic               div_start;
    logic [PT_W-1:0]    div_dividend;
    logic [SIZE_W-1:0]  div_divisor;
    logic               div_done;
    logic [PT_W-1:0]    div_quo;
    logic [SIZE_W-1:0]  div_rem;

    logic               ram_we;
    logic [TILE_AW-1:0] ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;
    entry_t             rmw_entry;
    entry_t             sweep_entry;

    assign cols_eff  = (cfg.cols == '0) ? GRID_W'(1) : cfg.cols;
    assign twe       = eff_size(cfg.tile_w);
    assign the       = eff_size(cfg.tile_h);
    assign grid_prod = cfg.cols * cfg.rows;
    assign accept    = cmd.valid && cmd.ready;
    assign is_idx_act = (act_reg inside {ACT_ADVANCE, ACT_RESET_IDX, ACT_QUERY_IDX});
    assign idx_ok    = (PROD_W'(cidx_reg) < grid_prod) && (cidx_reg < IDX_W'(MAX_TILES));
    assign pt_below  = (px_reg < cfg.origin_x) || (py_reg < cfg.origin_y);
    assign sw_last   = (sw_addr_reg == TILE_AW'(MAX_TILES - 1));

    // Row-major index of the located chunk; only used once column and row
    // are known to be inside the grid, so seven bits of each suffice.
    assign idx_calc = cy_reg[GRID_W-1:0] * cfg.cols + PROD_W'(cx_reg[GRID_W-1:0]);
    assign loc_ok   = (cx_reg < PT_W'(cfg.cols)) && (cy_reg < PT_W'(cfg.rows))
                   && (idx_calc < grid_prod) && (idx_calc < PROD_W'(MAX_TILES));

    assign prod_x = cx_reg[GRID_W-1:0] * twe;
    assign prod_y = cy_reg[TILE_AW-1:0] * the;

    // Edge neighbours: left before right, top before bottom.
    assign nb_h_left  = (wide_t'(px_reg) == bx_reg) && (cx_reg != '0);
    assign nb_h_right = (wide_t'(px_reg) == bx_reg + wide_t'(twe) - wide_t'(1))
                     && ((cx_reg + PT_W'(1)) < PT_W'(cfg.cols));
    assign nb_v_up    = (wide_t'(py_reg) == by_reg) && (cy_reg != '0);
    assign nb_v_down  = (wide_t'(py_reg) == by_reg + wide_t'(the) - wide_t'(1))
                     && ((cy_reg + PT_W'(1)) < PT_W'(cfg.rows));
    assign nb_h_idx   = nb_h_left ? ((PROD_W+1)'(idx_reg) - (PROD_W+1)'(1))
                                  : ((PROD_W+1)'(idx_reg) + (PROD_W+1)'(1));
    assign nb_v_idx   = nb_v_up ? ((PROD_W+1)'(idx_reg) - (PROD_W+1)'(cfg.cols))
                                : ((PROD_W+1)'(idx_reg) + (PROD_W+1)'(cfg.cols));
    assign nb_h_go    = (nb_h_left || nb_h_right) && (nb_h_idx < (PROD_W+1)'(MAX_TILES));
    assign nb_v_go    = (nb_v_up || nb_v_down) && (nb_v_idx < (PROD_W+1)'(MAX_TILES));

    assign rd_entry = entry_t'(ram_rdata);

    always_comb
    begin
        sweep_entry.active      = 1'b0;
        sweep_entry.next_active = 1'b0;
        sweep_entry.cur  = empty_rect(sw_bx_reg, sw_by_reg, wide_t'(sw_tw_reg),
                                      wide_t'(sw_th_reg));
        sweep_entry.work = sweep_entry.cur;
    end

    always_comb
    begin
        rmw_entry = rd_entry;
        case (op_reg)
            OP_MARK:
            begin
                rmw_entry.next_active = 1'b1;
                rmw_entry.work = mark_rect(rd_entry.work, mx_reg, my_reg, tbx_reg, tby_reg,
                                           wide_t'(twe), wide_t'(the));
            end
            OP_ADVANCE:
            begin
                rmw_entry.active      = rd_entry.next_active;
                rmw_entry.next_active = 1'b0;
                rmw_entry.cur         = rd_entry.work;
                rmw_entry.work = empty_rect(tbx_reg, tby_reg, wide_t'(twe), wide_t'(the));
            end
            default:
            begin
                rmw_entry.active      = 1'b0;
                rmw_entry.next_active = 1'b0;
                rmw_entry.cur  = empty_rect(tbx_reg, tby_reg, wide_t'(twe), wide_t'(the));
                rmw_entry.work = rmw_entry.cur;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (sw_last)
                begin
                    if (!sweep_cmd_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (grid_prod != '0)
                    begin
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (act_reg == ACT_RESET_ALL)
                begin
                    state_next = ST_SWEEP;
                end
                else if (is_idx_act)
                begin
                    if (!idx_ok)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (act_reg == ACT_QUERY_IDX)
                    begin
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        state_next = ST_DIV_I;
                    end
                end
                else if (pt_below)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_done)
                begin
                    state_next = ST_LOCATE;
                end
            end
            ST_DIV_I:
            begin
                if (div_done)
                begin
                    state_next = ST_BOUNDS;
                end
            end
            ST_BOUNDS:
            begin
                state_next = ST_RMW_RD;
            end
            ST_LOCATE:
            begin
                if (!loc_ok)
                begin
                    state_next = ST_DONE;
                end
                else if (act_reg == ACT_QUERY_PT)
                begin
                    state_next = ST_OUT_RD;
                end
                else if (act_reg == ACT_MARK_NB)
                begin
                    state_next = ST_NB_H;
                end
                else
                begin
                    state_next = ST_RMW_RD;
                end
            end
            ST_NB_H:
            begin
                state_next = nb_h_go ? ST_RMW_RD : ST_NB_V;
            end
            ST_NB_V:
            begin
                state_next = nb_v_go ? ST_RMW_RD : ST_OUT_RD;
            end
            ST_RMW_RD:
            begin
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                state_next = (nb_reg == NB_HORIZ) ? ST_NB_V : ST_OUT_RD;
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_CAP;
            end
            ST_OUT_CAP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        cmd.ready    = 1'b0;
        res_valid    = 1'b0;
        div_start    = 1'b0;
        div_dividend = PT_W'(cidx_reg);
        div_divisor  = SIZE_W'(cols_eff);
        ram_we       = 1'b0;
        ram_addr     = idx_reg;
        ram_wdata    = rmw_entry;
        case (state_reg)
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_addr  = sw_addr_reg;
                ram_wdata = sweep_entry;
            end
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            ST_DISPATCH:
            begin
                if (is_idx_act)
                begin
                    div_start = idx_ok && (act_reg != ACT_QUERY_IDX);
                end
                else
                begin
                    div_start    = (act_reg != ACT_RESET_ALL) && !pt_below;
                    div_dividend = px_reg - cfg.origin_x;
                    div_divisor  = twe;
                end
            end
            ST_DIV_X:
            begin
                div_start    = div_done;
                div_dividend = py_reg - cfg.origin_y;
                div_divisor  = the;
            end
            ST_RMW_RD:
            begin
                ram_addr = tgt_reg;
            end
            ST_RMW_WR:
            begin
                ram_we   = 1'b1;
                ram_addr = tgt_reg;
            end
            ST_DONE:
            begin
                res_valid = res_ready;
            end
            default:
            begin
                ram_addr = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_cmd_reg <= 1'b0;
            sw_addr_reg   <= '0;
            sw_col_reg    <= '0;
            sw_cols_reg   <= CFG_RESET.cols;
            sw_tw_reg     <= CFG_RESET.tile_w;
            sw_th_reg     <= CFG_RESET.tile_h;
            sw_ox_reg     <= CFG_RESET.origin_x;
            sw_bx_reg     <= wide_t'(CFG_RESET.origin_x);
            sw_by_reg     <= wide_t'(CFG_RESET.origin_y);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DISPATCH && act_reg == ACT_RESET_ALL)
            begin
                sweep_cmd_reg <= 1'b1;
                sw_addr_reg   <= '0;
                sw_col_reg    <= '0;
                sw_cols_reg   <= cols_eff;
                sw_tw_reg     <= twe;
                sw_th_reg     <= the;
                sw_ox_reg     <= cfg.origin_x;
                sw_bx_reg     <= wide_t'(cfg.origin_x);
                sw_by_reg     <= wide_t'(cfg.origin_y);
            end
            else if (state_reg == ST_SWEEP)
            begin
                sw_addr_reg <= sw_addr_reg + TILE_AW'(1);
                if (sw_col_reg + GRID_W'(1) == sw_cols_reg)
                begin
                    sw_col_reg <= '0;
                    sw_bx_reg  <= wide_t'(sw_ox_reg);
                    sw_by_reg  <= sw_by_reg + wide_t'(sw_th_reg);
                end
                else
                begin
                    sw_col_reg <= sw_col_reg + GRID_W'(1);
                    sw_bx_reg  <= sw_bx_reg + wide_t'(sw_tw_reg);
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_SWEEP:
            begin
                idx_reg <= '0;
                res_reg <= FAULT_RESULT;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_reg  <= action_t'(cmd.action);
                    px_reg   <= cmd.point_x;
                    py_reg   <= cmd.point_y;
                    cidx_reg <= cmd.chunk_index;
                end
            end
            ST_DISPATCH:
            begin
                res_reg <= FAULT_RESULT;
                nb_reg  <= NB_NONE;
                idx_reg <= cidx_reg[TILE_AW-1:0];
                tgt_reg <= cidx_reg[TILE_AW-1:0];
                if (act_reg == ACT_MARK || act_reg == ACT_MARK_NB)
                begin
                    op_reg <= OP_MARK;
                end
                else if (act_reg == ACT_ADVANCE)
                begin
                    op_reg <= OP_ADVANCE;
                end
                else
                begin
                    op_reg <= OP_RESET;
                end
            end
            ST_DIV_X:
            begin
                if (div_done)
                begin
                    cx_reg   <= div_quo;
                    remx_reg <= div_rem;
                end
            end
            ST_DIV_Y:
            begin
                if (div_done)
                begin
                    cy_reg   <= div_quo;
                    remy_reg <= div_rem;
                end
            end
            ST_DIV_I:
            begin
                if (div_done)
                begin
                    cx_reg <= PT_W'(div_rem);
                    cy_reg <= div_quo;
                end
            end
            ST_BOUNDS:
            begin
                tbx_reg <= wide_t'(prod_x) + wide_t'(cfg.origin_x);
                tby_reg <= wide_t'(prod_y) + wide_t'(cfg.origin_y);
            end
            ST_LOCATE:
            begin
                idx_reg <= idx_calc[TILE_AW-1:0];
                tgt_reg <= idx_calc[TILE_AW-1:0];
                bx_reg  <= wide_t'(px_reg) - wide_t'(remx_reg);
                by_reg  <= wide_t'(py_reg) - wide_t'(remy_reg);
                tbx_reg <= wide_t'(px_reg) - wide_t'(remx_reg);
                tby_reg <= wide_t'(py_reg) - wide_t'(remy_reg);
                mx_reg  <= wide_t'(px_reg);
                my_reg  <= wide_t'(py_reg);
            end
            ST_NB_H:
            begin
                tgt_reg <= nb_h_idx[TILE_AW-1:0];
                tby_reg <= by_reg;
                my_reg  <= wide_t'(py_reg);
                nb_reg  <= NB_HORIZ;
                if (nb_h_left)
                begin
                    tbx_reg <= bx_reg - wide_t'(twe);
                    mx_reg  <= wide_t'(px_reg) - wide_t'(1);
                end
                else
                begin
                    tbx_reg <= bx_reg + wide_t'(twe);
                    mx_reg  <= wide_t'(px_reg) + wide_t'(1);
                end
            end
            ST_NB_V:
            begin
                tgt_reg <= nb_v_idx[TILE_AW-1:0];
                tbx_reg <= bx_reg;
                mx_reg  <= wide_t'(px_reg);
                nb_reg  <= NB_VERT;
                if (nb_v_up)
                begin
                    tby_reg <= by_reg - wide_t'(the);
                    my_reg  <= wide_t'(py_reg) - wide_t'(1);
                end
                else
                begin
                    tby_reg <= by_reg + wide_t'(the);
                    my_reg  <= wide_t'(py_reg) + wide_t'(1);
                end
            end
            ST_OUT_CAP:
            begin
                res_reg.is_active <= rd_entry.active;
                res_reg.rect      <= rd_entry.cur;
                res_reg.idx       <= IDX_W'(idx_reg);
                res_reg.fault     <= 1'b0;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign res = res_reg;

    cdrt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    cdrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TILES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    `CDRT_ASSERT_NOW(a_ram_we_state, ram_we, (state_reg == ST_SWEEP) || (state_reg == ST_RMW_WR), "chunk memory written outside sweep or write-back")
    `CDRT_ASSERT_NEXT(a_accept_blocks, cmd.valid && cmd.ready, !cmd.ready, "second item accepted while one is in flight")
    `CDRT_ASSERT_NOW(a_fault_zero, res_valid && res.fault, (res.idx == '0) && !res.is_active && (res.rect == '0), "fault result carries nonzero fields")

endmodule

`default_nettype wire

### hdl/chunk_dirty_rect_tracker.sv
// Top level of the chunk dirty rectangle tracker: configuration registers,
// result register and the sequencer. Uses cdrt_pkg, both channel interfaces
// and cdrt_ctrl.
//
//  Channel   Direction  Handshake     Carries
//  cmd       in         valid/ready   action, point_x, point_y, chunk_index
//  rsp       out        valid/ready   is_active, four rectangle bounds, index, fault
//  cfg       in         cfg_wr_en     cfg_index selects a register, cfg_data is the value
//
// One item is worked at a time. An index query uses no divider pass; advance and
// reset by index use one 14-step pass of the shared divider; point actions use
// two divider passes, plus a read-modify-write per marked neighbour.
// After reset, and for every reset-all item, a sweep writes all 1024 chunk
// entries, one per cycle, before the next item is taken.
// A stalled rsp holds the result register; the next item is still accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "chunk_dirty_rect_tracker_defines.svh"

module chunk_dirty_rect_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cdrt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cdrt_pkg::CFG_DATA_W-1:0]     cfg_data,
    cdrt_cmd_if.sink                            cmd,
    cdrt_rsp_if.source                          rsp
);
    import cdrt_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    logic    rsp_valid_reg;
    result_t rsp_data_reg;

    // Configuration writes touch only these registers, never chunk state.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COLS:     cfg_next.cols     = cfg_data[GRID_W-1:0];
                REG_ROWS:     cfg_next.rows     = cfg_data[GRID_W-1:0];
                REG_TILE_W:   cfg_next.tile_w   = cfg_data[SIZE_W-1:0];
                REG_TILE_H:   cfg_next.tile_h   = cfg_data[SIZE_W-1:0];
                REG_ORIGIN_X: cfg_next.origin_x = cfg_data[PT_W-1:0];
                REG_ORIGIN_Y: cfg_next.origin_y = cfg_data[PT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The result register frees the sequencer as soon as a result is handed over.
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.is_active       = rsp_data_reg.is_active;
    assign rsp.rect_x_min      = rsp_data_reg.rect.x_min;
    assign rsp.rect_y_min      = rsp_data_reg.rect.y_min;
    assign rsp.rect_x_max      = rsp_data_reg.rect.x_max;
    assign rsp.rect_y_max      = rsp_data_reg.rect.y_max;
    assign rsp.addressed_index = rsp_data_reg.idx;
    assign rsp.fault           = rsp_data_reg.fault;

    cdrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    `CDRT_ASSERT_NOW(a_slot_free, res_valid, res_ready, "result handed over while result register is full")
    `CDRT_ASSERT_NEXT(a_result_loaded, res_valid && res_ready, rsp.valid, "handed result not shown on rsp")
    `CDRT_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.addressed_index), "waiting result changed before it was taken")

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for chunk_dirty_rect_tracker: directed and random actions under
// several grid settings, with random idling on both channels and one long response stall.
// Depends on cdrt_pkg, cdrt_cmd_if, cdrt_rsp_if and the block itself.
`timescale 1ns / 1ps

module testbench;
    import cdrt_pkg::*;

    // Field indexes into the stored rectangles of the predictor.
    localparam int XMN = 0;
    localparam int YMN = 1;
    localparam int XMX = 2;
    localparam int YMX = 3;

    // The block sweeps all chunk entries after reset and after every reset-all item.
    // Configuration writes wait this long after the last result so the sweep is done.
    localparam int SETTLE_CYCLES = 1200;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 8000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cdrt_cmd_if cmd_ch();
    cdrt_rsp_if rsp_ch();

    chunk_dirty_rect_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: its own copy of the configuration and of every chunk.
    // ------------------------------------------------------------------
    longint grid_cols, grid_rows, tile_w, tile_h, org_x, org_y;
    bit     active_now[MAX_TILES];
    bit     active_next[MAX_TILES];
    longint shown_rect[MAX_TILES][4];
    longint pending_rect[MAX_TILES][4];
    longint recent_chunk;

    result_t expected_results[$];
    int      mismatch_count = 0;
    bit      calm = 1'b0;
    int      hold_requests = 0;
    int      hold_served = 0;

    function automatic longint sat16(longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic longint tw_e();
        return (tile_w == 0) ? 1 : tile_w;
    endfunction

    function automatic longint th_e();
        return (tile_h == 0) ? 1 : tile_h;
    endfunction

    function automatic longint chunks_in_use();
        longint n;
        n = grid_cols * grid_rows;
        return (n > MAX_TILES) ? MAX_TILES : n;
    endfunction

    function automatic void chunk_origin(longint idx, output longint bx, output longint by);
        longint c;
        c = (grid_cols == 0) ? 1 : grid_cols;
        bx = (idx % c) * tw_e() + org_x;
        by = (idx / c) * th_e() + org_y;
    endfunction

    // An empty rectangle lies one past the far bound and one before the near bound.
    function automatic void clear_pending(longint idx);
        longint bx, by;
        chunk_origin(idx, bx, by);
        pending_rect[idx][XMN] = sat16(bx + tw_e());
        pending_rect[idx][XMX] = sat16(bx - 1);
        pending_rect[idx][YMN] = sat16(by + th_e());
        pending_rect[idx][YMX] = sat16(by - 1);
    endfunction

    function automatic void clear_chunk(longint idx);
        active_now[idx] = 1'b0;
        active_next[idx] = 1'b0;
        clear_pending(idx);
        shown_rect[idx] = pending_rect[idx];
    endfunction

    function automatic void clear_all_chunks();
        for (int i = 0; i < MAX_TILES; i++)
            clear_chunk(i);
    endfunction

    function automatic bit find_chunk(longint x, longint y, output longint cx,
                                      output longint cy);
        cx = 0;
        cy = 0;
        if (x < org_x || y < org_y)
            return 1'b0;
        cx = (x - org_x) / tw_e();
        cy = (y - org_y) / th_e();
        return (cx < grid_cols) && (cy < grid_rows);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Widen the working rectangle by -2/+3 around the point, kept inside the chunk.
    function automatic void widen_at(longint x, longint y);
        longint cx, cy, idx, bx, by, lo, hi;
        if (!find_chunk(x, y, cx, cy))
            return;
        idx = cy * grid_cols + cx;
        if (idx >= MAX_TILES)
            return;
        chunk_origin(idx, bx, by);
        active_next[idx] = 1'b1;
        lo = (x - 2 < pending_rect[idx][XMN]) ? x - 2 : pending_rect[idx][XMN];
        hi = (x + 3 > pending_rect[idx][XMX]) ? x + 3 : pending_rect[idx][XMX];
        pending_rect[idx][XMN] = sat16(clip(lo, bx, bx + tw_e()));
        pending_rect[idx][XMX] = sat16(clip(hi, bx, bx + tw_e()));
        lo = (y - 2 < pending_rect[idx][YMN]) ? y - 2 : pending_rect[idx][YMN];
        hi = (y + 3 > pending_rect[idx][YMX]) ? y + 3 : pending_rect[idx][YMX];
        pending_rect[idx][YMN] = sat16(clip(lo, by, by + th_e()));
        pending_rect[idx][YMX] = sat16(clip(hi, by, by + th_e()));
        recent_chunk = idx;
    endfunction

    function automatic result_t predict_action(action_t act, longint x, longint y,
                                               longint ci);
        longint idx, cx, cy, bx, by;
        bit ok;
        result_t r;
        idx = 0;
        cx = 0;
        cy = 0;
        if (act == ACT_ADVANCE || act == ACT_RESET_IDX || act == ACT_QUERY_IDX)
        begin
            idx = ci;
            ok = idx < chunks_in_use();
        end
        else if (act == ACT_RESET_ALL)
        begin
            clear_all_chunks();
            ok = chunks_in_use() > 0;
        end
        else
        begin
            ok = find_chunk(x, y, cx, cy);
            if (ok)
            begin
                idx = cy * grid_cols + cx;
                ok = idx < chunks_in_use();
            end
        end
        if (!ok)
            return FAULT_RESULT;

        case (act)
            ACT_MARK: widen_at(x, y);
            ACT_MARK_NB:
            begin
                // The addressed chunk itself is left alone; only edge neighbours grow.
                chunk_origin(idx, bx, by);
                if (x == bx && cx > 0)
                    widen_at(x - 1, y);
                else if (x == bx + tw_e() - 1 && cx + 1 < grid_cols)
                    widen_at(x + 1, y);
                if (y == by && cy > 0)
                    widen_at(x, y - 1);
                else if (y == by + th_e() - 1 && cy + 1 < grid_rows)
                    widen_at(x, y + 1);
            end
            ACT_ADVANCE:
            begin
                active_now[idx] = active_next[idx];
                active_next[idx] = 1'b0;
                shown_rect[idx] = pending_rect[idx];
                clear_pending(idx);
            end
            ACT_RESET_IDX, ACT_RESET_PT: clear_chunk(idx);
            default: ;
        endcase

        r.is_active = active_now[idx];
        r.rect.x_min = coord_t'(shown_rect[idx][XMN]);
        r.rect.y_min = coord_t'(shown_rect[idx][YMN]);
        r.rect.x_max = coord_t'(shown_rect[idx][XMX]);
        r.rect.y_max = coord_t'(shown_rect[idx][YMX]);
        r.idx = IDX_W'(idx);
        r.fault = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Offers one item after a random gap and records its expected result once taken.
    // It is entered and left just after a rising edge.
    task automatic send_item(action_t act, int x, int y, int ci);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.action <= act;
        cmd_ch.point_x <= PT_W'(x);
        cmd_ch.point_y <= PT_W'(y);
        cmd_ch.chunk_index <= IDX_W'(ci);
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        expected_results.push_back(predict_action(act, x, y, ci));
    endtask

    // Drops valid and waits until every result is in and any sweep has finished.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all six registers, one per cycle, and mirrors them in the predictor.
    task automatic load_grid(int cols, int rows, int tw, int th, int ox, int oy);
        int vals[6];
        vals = '{cols, rows, tw, th, ox, oy};
        wait_idle();
        for (int i = 0; i < 6; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= CFG_DATA_W'(vals[i]);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        grid_cols = cols & 'h7f;
        grid_rows = rows & 'h7f;
        tile_w = tw & 'h1fff;
        tile_h = th & 'h1fff;
        org_x = ox & 'h3fff;
        org_y = oy & 'h3fff;
    endtask

    // A point that lands in the grid most of the time, often on a chunk edge.
    function automatic void pick_point(output int x, output int y);
        longint cx, cy, off_x, off_y, c, r;
        c = (grid_cols == 0) ? 1 : grid_cols;
        r = (grid_rows == 0) ? 1 : grid_rows;
        cx = $urandom_range(0, c - 1);
        cy = $urandom_range(0, r - 1);
        case ($urandom_range(0, 3))
            0: off_x = 0;
            1: off_x = tw_e() - 1;
            default: off_x = $urandom_range(0, tw_e() - 1);
        endcase
        case ($urandom_range(0, 3))
            0: off_y = 0;
            1: off_y = th_e() - 1;
            default: off_y = $urandom_range(0, th_e() - 1);
        endcase
        x = org_x + cx * tw_e() + off_x;
        y = org_y + cy * th_e() + off_y;
        if (x > 16383)
            x = $urandom_range(org_x, 16383);
        if (y > 16383)
            y = $urandom_range(org_y, 16383);
    endfunction

    // Mostly well-formed traffic: marks followed by advances of the chunks that were
    // marked; about a tenth is noise: any point, any index, any action but reset-all.
    task automatic random_actions(int count);
        int x, y, ci, r;
        action_t act;
        for (int n = 0; n < count; n++)
        begin
            pick_point(x, y);
            ci = (chunks_in_use() > 0) ? $urandom_range(0, chunks_in_use() - 1)
                                       : $urandom_range(0, 4095);
            r = $urandom_range(0, 199);
            if (r < 70)
                act = ACT_MARK;
            else if (r < 100)
                act = ACT_MARK_NB;
            else if (r < 130)
            begin
                act = ACT_ADVANCE;
                if ($urandom_range(0, 2) != 0)
                    ci = recent_chunk;
            end
            else if (r < 145)
                act = ACT_QUERY_IDX;
            else if (r < 160)
                act = ACT_QUERY_PT;
            else if (r < 168)
                act = ACT_RESET_IDX;
            else if (r < 176)
                act = ACT_RESET_PT;
            else if (r < 178)
                act = ACT_RESET_ALL;
            else
            begin
                act = action_t'($urandom_range(0, 6));
                x = $urandom_range(0, 16383);
                y = $urandom_range(0, 16383);
                ci = $urandom_range(0, 4095);
            end
            send_item(act, x, y, ci);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset grid: 8 x 8 chunks of 64 cells at the world origin.
    task automatic test_directed();
        send_item(ACT_MARK, 0, 0, 0);
        send_item(ACT_MARK, 63, 63, 0);
        send_item(ACT_ADVANCE, 0, 0, 0);
        send_item(ACT_QUERY_IDX, 0, 0, 0);
        // Top-left corner of chunk 9 marks the chunk to its left and the one above.
        send_item(ACT_MARK_NB, 64, 64, 0);
        // Bottom-right corner of chunk 9 marks the chunk to its right and the one below.
        send_item(ACT_MARK_NB, 127, 127, 0);
        // The corner of the grid marks no neighbour at all.
        send_item(ACT_MARK_NB, 0, 0, 0);
        send_item(ACT_ADVANCE, 0, 0, 8);
        send_item(ACT_ADVANCE, 0, 0, 17);
        send_item(ACT_QUERY_PT, 70, 5, 0);
        send_item(ACT_QUERY_IDX, 0, 0, 8);
        send_item(ACT_RESET_IDX, 0, 0, 8);
        send_item(ACT_RESET_PT, 5, 70, 0);
        send_item(ACT_QUERY_IDX, 0, 0, 4095);
        send_item(ACT_QUERY_PT, 16383, 16383, 0);
        send_item(ACT_MARK, 511, 511, 0);
        send_item(ACT_ADVANCE, 0, 0, 63);
        send_item(ACT_QUERY_PT, 511, 511, 0);
        send_item(ACT_MARK, 1, 1, 0);
        send_item(ACT_ADVANCE, 0, 0, 0);
        send_item(ACT_RESET_ALL, 0, 0, 0);
        send_item(ACT_QUERY_IDX, 0, 0, 63);
        send_item(ACT_ADVANCE, 0, 0, 0);
    endtask

    // Several grid settings, the extremes among them, each with a random burst.
    task automatic test_grid_settings();
        load_grid(8, 8, 64, 64, 0, 0);
        random_actions(180);
        // Single-cell chunks; the 64 x 64 grid is cut to the first 1024 chunks.
        load_grid(64, 64, 1, 1, 100, 200);
        send_item(ACT_QUERY_IDX, 0, 0, 1024);
        send_item(ACT_MARK, 99, 200, 0);
        random_actions(180);
        // One huge chunk at the far corner; its bounds reach past the 14-bit point range.
        load_grid(1, 1, 4096, 4096, 16383, 16383);
        send_item(ACT_MARK, 16383, 16383, 0);
        send_item(ACT_ADVANCE, 0, 0, 0);
        random_actions(100);
        // Zero sized tiles act as one cell.
        load_grid(3, 7, 0, 0, 5, 9);
        random_actions(150);
        // Zero columns: nothing exists and even reset all faults.
        load_grid(0, 5, 16, 16, 0, 0);
        send_item(ACT_RESET_ALL, 0, 0, 0);
        random_actions(40);
        load_grid(64, 2, 4096, 3, 16383, 16383);
        random_actions(120);
        load_grid(5, 64, 7, 13, 1000, 2000);
        calm = 1'b1;
        random_actions(120);
        calm = 1'b0;
        random_actions(120);
        load_grid(64, 1, 200, 8191, 300, 0);
        random_actions(120);
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        load_grid(4, 4, 32, 32, 10, 10);
        hold_requests++;
        calm = 1'b1;
        random_actions(30);
        calm = 1'b0;
    endtask

    initial
    begin
        cmd_ch.valid = 1'b0;
        cmd_ch.action = ACT_MARK;
        cmd_ch.point_x = '0;
        cmd_ch.point_y = '0;
        cmd_ch.chunk_index = '0;
        grid_cols = 8;
        grid_rows = 8;
        tile_w = 64;
        tile_h = 64;
        org_x = 0;
        org_y = 0;
        recent_chunk = 0;
        clear_all_chunks();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // Let the clearing pass after reset finish before the first item.
        repeat (SETTLE_CYCLES) @(posedge clk);
        test_directed();
        test_grid_settings();
        test_backpressure();
        wait_idle();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, the long hold when asked, and the result check.
    // ------------------------------------------------------------------
    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    initial
    begin
        int stall_left;
        result_t want;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with no item waiting for it", $time);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("is_active", want.is_active, rsp_ch.is_active);
                    compare_field("rect_x_min", want.rect.x_min, rsp_ch.rect_x_min);
                    compare_field("rect_y_min", want.rect.y_min, rsp_ch.rect_y_min);
                    compare_field("rect_x_max", want.rect.x_max, rsp_ch.rect_x_max);
                    compare_field("rect_y_max", want.rect.y_max, rsp_ch.rect_y_max);
                    compare_field("addressed_index", want.idx, rsp_ch.addressed_index);
                    compare_field("fault", want.fault, rsp_ch.fault);
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 15)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog: too long without any item or register write moving ends the run.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                cfg_wr_en || !rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule

### files.f
+incdir+hdl
hdl/cdrt_pkg.sv
hdl/cdrt_cmd_if.sv
hdl/cdrt_rsp_if.sv
hdl/cdrt_ram.sv
hdl/cdrt_div.sv
hdl/cdrt_ctrl.sv
hdl/chunk_dirty_rect_tracker.sv
verif/testbench.sv
